// ===== rtl/core/gbba_pkg.sv =====
package gbba_pkg;

	// Fixed field widths
	localparam int INODE_W   = 24;
	localparam int BLOCK_W   = 14;
	localparam int IPG_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FDB = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IPG = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_SPACE     = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_OUT_OF_RANGE = 2'd3
	} status_t;

	// Start request to the divider
	typedef struct packed {
		logic               start;
		logic [INODE_W-1:0] dividend;
		logic [IPG_W-1:0]   divisor;
	} div_req_t;

endpackage

// ===== rtl/core/gbba_ram.sv =====
module gbba_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                            rdata
);

	logic [W-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/gbba_ffz.sv =====
module gbba_ffz #(
	parameter int W = 32
) (
	input  logic [W-1:0]                          word,
	output logic                                  found,
	output logic [((W > 1) ? $clog2(W) : 1)-1:0] idx
);

	localparam int IW = (W > 1) ? $clog2(W) : 1;

	// Lowest clear bit wins
	always_comb begin
		found = ~&word;
		idx   = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				idx = IW'(i);
			end
		end
	end

endmodule

// ===== rtl/core/gbba_div.sv =====
module gbba_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gbba_pkg::div_req_t             req,
	output logic                           done,
	output logic [gbba_pkg::INODE_W-1:0]   quotient
);

	import gbba_pkg::*;

	localparam int STEP_W = $clog2(INODE_W + 1);

	logic [STEP_W-1:0]  step_q;
	logic               done_q;
	logic [IPG_W-1:0]   rem_q;
	logic [IPG_W-1:0]   dvs_q;
	logic [INODE_W-1:0] quo_q;
	logic [IPG_W:0]     trial;
	logic [IPG_W:0]     diff;
	logic               fits;

	// One restoring step: bring down the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[INODE_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= STEP_W'(INODE_W);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? diff[IPG_W-1:0] : trial[IPG_W-1:0];
			quo_q <= {quo_q[INODE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/grouped_bitmap_block_allocator.sv =====
// Free: bitmap read, update, then output; block 0 and out-of-range requests go straight to output.
// Allocate: a divide for the preferred group when an inode is given and ipg_q is nonzero, then a count read
//   and check per group visited, a scan of up to BLOCKS_PER_GROUP/WORD_W bitmap words, and a write-back
//   before the result is posted; when the device is full the result is posted at once.
// One item is in work at a time; in_ready rises in the same cycle as out_valid for its result.
// Reset: clears the bitmap and sets each group count to BLOCKS_PER_GROUP in a pass over all bitmap words.
module grouped_bitmap_block_allocator #(
	parameter int GROUPS           = 8,
	parameter int BLOCKS_PER_GROUP = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [gbba_pkg::INODE_W-1:0]       inode_number,
	input  logic [gbba_pkg::BLOCK_W-1:0]       block_number,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [gbba_pkg::BLOCK_W-1:0]       allocated_block,
	output logic [1:0]                         status,
	input  logic                               cfg_we,
	input  logic [gbba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbba_pkg::CFG_W-1:0]         cfg_data
);

	import gbba_pkg::*;

	// Bitmap word width: largest of 32/16 dividing the group size, else 8
	localparam int WORD_W = (BLOCKS_PER_GROUP % 32 == 0) ? 32 :
		((BLOCKS_PER_GROUP % 16 == 0) ? 16 : 8);
	localparam int WSH   = $clog2(WORD_W);
	localparam int WPG   = BLOCKS_PER_GROUP / WORD_W;
	localparam int WORDS = GROUPS * WPG;
	localparam int TOTAL = GROUPS * BLOCKS_PER_GROUP;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GCW   = $clog2(GROUPS + 1);
	localparam int WI_W  = (WPG > 1) ? $clog2(WPG) : 1;
	localparam int WC_W  = $clog2(WPG + 1);
	localparam int CNT_W = $clog2(BLOCKS_PER_GROUP + 1);
	localparam int TOT_W = $clog2(TOTAL + 1);

	// Group of a freed block by reciprocal multiply, exact for any 14-bit offset
	localparam int     RS   = BLOCK_W + $clog2(BLOCKS_PER_GROUP);
	localparam longint RM   = ((longint'(1) << RS) + longint'(BLOCKS_PER_GROUP - 1)) /
		longint'(BLOCKS_PER_GROUP);
	localparam int     RP_W = 2 * BLOCK_W + 2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_GRP_RD,
		S_GRP_CHK,
		S_WSCAN,
		S_ALLOC_WR,
		S_FREE_RD,
		S_FREE_CHK,
		S_FIN
	} state_t;

	state_t             state_q;
	logic               fdb_q;
	logic [IPG_W-1:0]   ipg_q;
	logic [TOT_W-1:0]   total_q;
	logic [AW-1:0]      clr_q;
	logic [GW-1:0]      cur_g_q;
	logic [GW-1:0]      pref_q;
	logic               pref_vld_q;
	logic               in_pref_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WC_W-1:0]    w_iss_q;
	logic               rd_vld_s1;
	logic [WI_W-1:0]    w_s1;
	logic [AW-1:0]      hit_addr_q;
	logic [WORD_W-1:0]  hit_word_q;
	logic [WSH-1:0]     hit_bit_q;
	logic [WI_W-1:0]    hit_w_q;
	logic [AW-1:0]      fr_addr_q;
	logic [WSH-1:0]     fr_bit_q;
	logic [BLOCK_W-1:0] res_blk_q;
	status_t            res_st_q;
	logic               out_valid_q;
	logic [BLOCK_W-1:0] out_blk_q;
	status_t            out_st_q;

	// Memory ports
	logic              bm_we;
	logic [AW-1:0]     bm_waddr;
	logic [WORD_W-1:0] bm_wdata;
	logic [AW-1:0]     bm_raddr;
	logic [WORD_W-1:0] bm_rdata;
	logic              cn_we;
	logic [GW-1:0]     cn_waddr;
	logic [CNT_W-1:0]  cn_wdata;
	logic [GW-1:0]     cn_raddr;
	logic [CNT_W-1:0]  cn_rdata;

	// Datapath
	logic [AW:0]          base_ext;
	logic [AW:0]          scan_addr_ext;
	logic [AW:0]          hit_addr_ext;
	logic                 fz_found;
	logic [WSH-1:0]       fz_idx;
	logic [GCW-1:0]       cand;
	logic                 grp_end;
	logic [BLOCK_W:0]     rel;
	logic                 oor;
	logic [31:0]          rel_word;
	logic [RP_W-1:0]      grp_prod;
	logic [GW-1:0]        fr_grp;
	logic [INODE_W-1:0]   inode_m1;
	logic [31:0]          blk_sum;
	logic                 accept;
	div_req_t             div_req;
	logic                 div_done;
	logic [INODE_W-1:0]   div_quo;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_ready = (state_q == S_IDLE);

	// Word addresses within the current group
	always_comb begin
		base_ext      = (AW + 1)'(cur_g_q) * (AW + 1)'(WPG);
		scan_addr_ext = base_ext + (AW + 1)'(w_iss_q);
		hit_addr_ext  = base_ext + (AW + 1)'(w_s1);
	end

	// Next group to try: preferred first, then ascending, skipping the preferred
	always_comb begin
		cand = in_pref_q ? '0 : GCW'(cur_g_q) + GCW'(1);
		if (pref_vld_q && (cand == GCW'(pref_q))) begin
			cand = cand + GCW'(1);
		end
		grp_end = (cand >= GCW'(GROUPS));
	end

	// Free request decode
	always_comb begin
		rel      = {1'b0, block_number} - (BLOCK_W + 1)'(fdb_q);
		oor      = ({1'b0, block_number} < (BLOCK_W + 1)'(fdb_q)) ||
			(32'(rel) >= 32'(TOTAL));
		rel_word = 32'(rel) >> WSH;
		grp_prod = RP_W'(rel[BLOCK_W-1:0]) * RP_W'(RM);
		fr_grp   = GW'(grp_prod >> RS);
		inode_m1 = inode_number - INODE_W'(1);
	end

	// Allocated block number
	assign blk_sum = 32'(cur_g_q) * 32'(BLOCKS_PER_GROUP) +
		((32'(hit_w_q) << WSH) | 32'(hit_bit_q)) + 32'(fdb_q);

	// Divider start: preferred group for allocate
	always_comb begin
		div_req.start    = accept && (mode == MODE_ALLOC) && (total_q != '0) &&
			(inode_number != '0) && (ipg_q != '0);
		div_req.dividend = inode_m1;
		div_req.divisor  = ipg_q;
	end

	// Memory port steering
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = hit_addr_q;
		bm_wdata = hit_word_q | (WORD_W'(1) << hit_bit_q);
		bm_raddr = scan_addr_ext[AW-1:0];
		cn_we    = 1'b0;
		cn_waddr = cur_g_q;
		cn_wdata = cnt_q - CNT_W'(1);
		cn_raddr = cur_g_q;
		unique case (state_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_q;
				bm_wdata = '0;
				cn_we    = ({1'b0, clr_q} < (AW + 1)'(GROUPS));
				cn_waddr = clr_q[GW-1:0];
				cn_wdata = CNT_W'(BLOCKS_PER_GROUP);
			end
			S_ALLOC_WR: begin
				bm_we = 1'b1;
				cn_we = 1'b1;
			end
			S_FREE_RD: begin
				bm_raddr = fr_addr_q;
			end
			S_FREE_CHK: begin
				bm_waddr = fr_addr_q;
				bm_wdata = bm_rdata & ~(WORD_W'(1) << fr_bit_q);
				cn_wdata = (cn_rdata < CNT_W'(BLOCKS_PER_GROUP)) ?
					cn_rdata + CNT_W'(1) : cn_rdata;
				if (bm_rdata[fr_bit_q]) begin
					bm_we = 1'b1;
					cn_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	gbba_ram #(
		.W     (WORD_W),
		.DEPTH (WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	gbba_ram #(
		.W     (CNT_W),
		.DEPTH (GROUPS)
	) u_counts (
		.clk   (clk),
		.we    (cn_we),
		.waddr (cn_waddr),
		.wdata (cn_wdata),
		.raddr (cn_raddr),
		.rdata (cn_rdata)
	);

	gbba_ffz #(
		.W (WORD_W)
	) u_ffz (
		.word  (bm_rdata),
		.found (fz_found),
		.idx   (fz_idx)
	);

	gbba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			fdb_q       <= 1'b1;
			ipg_q       <= IPG_W'(1024);
			total_q     <= TOT_W'(TOTAL);
			cur_g_q     <= '0;
			pref_q      <= '0;
			pref_vld_q  <= 1'b0;
			in_pref_q   <= 1'b0;
			w_iss_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FDB: fdb_q <= cfg_data[0];
					CFG_IPG: ipg_q <= cfg_data;
				endcase
			end
			// Output beat taken and nothing new posted this cycle
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						fr_addr_q <= rel_word[AW-1:0];
						fr_bit_q  <= rel[WSH-1:0];
						res_blk_q <= '0;
						if (mode == MODE_FREE) begin
							if (block_number == '0) begin
								res_st_q <= ST_OK;
								state_q  <= S_FIN;
							end else if (oor) begin
								res_st_q <= ST_OUT_OF_RANGE;
								state_q  <= S_FIN;
							end else begin
								cur_g_q <= fr_grp;
								state_q <= S_FREE_RD;
							end
						end else if (total_q == '0) begin
							res_st_q <= ST_NO_SPACE;
							state_q  <= S_FIN;
						end else if ((inode_number == '0) || (ipg_q == '0)) begin
							pref_vld_q <= 1'b0;
							in_pref_q  <= 1'b0;
							cur_g_q    <= '0;
							state_q    <= S_GRP_RD;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_quo < INODE_W'(GROUPS)) begin
							pref_vld_q <= 1'b1;
							in_pref_q  <= 1'b1;
							pref_q     <= div_quo[GW-1:0];
							cur_g_q    <= div_quo[GW-1:0];
						end else begin
							pref_vld_q <= 1'b0;
							in_pref_q  <= 1'b0;
							cur_g_q    <= '0;
						end
						state_q <= S_GRP_RD;
					end
				end
				S_GRP_RD: begin
					state_q <= S_GRP_CHK;
				end
				S_GRP_CHK: begin
					if (cn_rdata == '0) begin
						if (grp_end) begin
							res_st_q <= ST_NO_SPACE;
							state_q  <= S_FIN;
						end else begin
							cur_g_q   <= cand[GW-1:0];
							in_pref_q <= 1'b0;
							state_q   <= S_GRP_RD;
						end
					end else begin
						cnt_q     <= cn_rdata;
						w_iss_q   <= '0;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_WSCAN;
					end
				end
				S_WSCAN: begin
					// Read one word per cycle, test the word read in the cycle before
					if (rd_vld_s1 && fz_found) begin
						hit_addr_q <= hit_addr_ext[AW-1:0];
						hit_word_q <= bm_rdata;
						hit_bit_q  <= fz_idx;
						hit_w_q    <= w_s1;
						state_q    <= S_ALLOC_WR;
					end else if (rd_vld_s1 && (w_s1 == WI_W'(WPG - 1))) begin
						// Count said free but every bit is set: treat as full
						if (grp_end) begin
							res_st_q <= ST_NO_SPACE;
							state_q  <= S_FIN;
						end else begin
							cur_g_q   <= cand[GW-1:0];
							in_pref_q <= 1'b0;
							state_q   <= S_GRP_RD;
						end
					end else if (w_iss_q < WC_W'(WPG)) begin
						rd_vld_s1 <= 1'b1;
						w_s1      <= w_iss_q[WI_W-1:0];
						w_iss_q   <= w_iss_q + WC_W'(1);
					end else begin
						rd_vld_s1 <= 1'b0;
					end
				end
				S_ALLOC_WR: begin
					if (total_q != '0) begin
						total_q <= total_q - TOT_W'(1);
					end
					res_blk_q <= blk_sum[BLOCK_W-1:0];
					res_st_q  <= ST_OK;
					state_q   <= S_FIN;
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (bm_rdata[fr_bit_q]) begin
						res_st_q <= ST_OK;
						if (total_q < TOT_W'(TOTAL)) begin
							total_q <= total_q + TOT_W'(1);
						end
					end else begin
						res_st_q <= ST_ALREADY_FREE;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_blk_q   <= res_blk_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign allocated_block = out_blk_q;
	assign status          = out_st_q;

endmodule

// ===== test/grouped_bitmap_block_allocator_tb.sv =====
`timescale 1ns / 100ps

module grouped_bitmap_block_allocator_tb;
	import gbba_pkg::*;

	localparam int NUM_GROUPS   = 8;
	localparam int GROUP_BLOCKS = 1024;
	localparam int TOTAL_BLOCKS = NUM_GROUPS * GROUP_BLOCKS;
	localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
	localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either side
	localparam int DRAIN_CYCLES = 400;   // idle wait before the final verdict

	typedef struct packed {
		logic [BLOCK_W-1:0] blk;
		status_t            st;
	} answer_t;

	typedef struct packed {
		logic               m;
		logic [INODE_W-1:0] ino;
		logic [BLOCK_W-1:0] bn;
		logic               fixed;
		answer_t            want;
	} plan_row_t;

	// Block ports
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               mode         = MODE_ALLOC;
	logic [INODE_W-1:0] inode_number = '0;
	logic [BLOCK_W-1:0] block_number = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [BLOCK_W-1:0] allocated_block;
	logic [1:0]         status;
	logic               cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = CFG_FDB;
	logic [CFG_W-1:0]   cfg_data     = '0;

	// Shadow of the allocator state
	bit          used_map [TOTAL_BLOCKS];
	int unsigned grp_free [NUM_GROUPS];
	int unsigned free_total;
	int unsigned first_block;
	int unsigned inodes_per_grp;
	int unsigned held [$];         // relative indexes of blocks handed out
	answer_t     answers_due [$];

	// Traffic control
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          hold_asked = 0;
	int          hold_seen;
	int          hold_left;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	answer_t     head;

	// Start-of-run plan: fresh map, first data block 1, 1024 inodes per group
	plan_row_t plan [0:15] = '{
		'{MODE_ALLOC, 24'd0,        14'd0,      1'b1, '{14'd1, ST_OK}},
		'{MODE_ALLOC, 24'd1,        14'd0,      1'b0, '{14'd0, ST_OK}},
		'{MODE_ALLOC, 24'd1025,     14'd0,      1'b0, '{14'd0, ST_OK}},
		'{MODE_ALLOC, 24'hFFFFFF,   14'd0,      1'b0, '{14'd0, ST_OK}},
		'{MODE_ALLOC, 24'd8193,     14'd0,      1'b0, '{14'd0, ST_OK}},
		'{MODE_ALLOC, 24'd8192,     14'd0,      1'b0, '{14'd0, ST_OK}},
		'{MODE_ALLOC, 24'd0,        14'h3FFF,   1'b0, '{14'd0, ST_OK}},
		'{MODE_FREE,  24'hFFFFFF,   14'd0,      1'b1, '{14'd0, ST_OK}},
		'{MODE_FREE,  24'd0,        14'd8193,   1'b1, '{14'd0, ST_OUT_OF_RANGE}},
		'{MODE_FREE,  24'd0,        14'h3FFF,   1'b1, '{14'd0, ST_OUT_OF_RANGE}},
		'{MODE_FREE,  24'd0,        14'd8192,   1'b1, '{14'd0, ST_ALREADY_FREE}},
		'{MODE_FREE,  24'd0,        14'd1,      1'b0, '{14'd0, ST_OK}},
		'{MODE_FREE,  24'd0,        14'd1,      1'b1, '{14'd0, ST_ALREADY_FREE}},
		'{MODE_ALLOC, 24'd0,        14'd0,      1'b0, '{14'd0, ST_OK}},
		'{MODE_FREE,  24'd0,        14'd7169,   1'b0, '{14'd0, ST_OK}},
		'{MODE_FREE,  24'd0,        14'd1025,   1'b0, '{14'd0, ST_OK}}
	};

	grouped_bitmap_block_allocator #(
		.GROUPS          (NUM_GROUPS),
		.BLOCKS_PER_GROUP(GROUP_BLOCKS)
	) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Lowest clear bit of one group; marks it used
	function automatic logic take_lowest(input int unsigned g, output logic [BLOCK_W-1:0] blk);
		int unsigned base;
		blk = '0;
		if (g >= NUM_GROUPS || grp_free[g] == 0)
			return 1'b0;
		base = g * GROUP_BLOCKS;
		for (int unsigned off = 0; off < GROUP_BLOCKS; off++) begin
			if (!used_map[base + off]) begin
				used_map[base + off] = 1'b1;
				grp_free[g]--;
				if (free_total != 0)
					free_total--;
				blk = BLOCK_W'(base + off + first_block);
				held.push_back(base + off);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// One request against the shadow state
	function automatic answer_t run_allocator(input logic m, input logic [INODE_W-1:0] ino,
			input logic [BLOCK_W-1:0] bn);
		answer_t          a;
		int unsigned      pref, bnum, rel, g;
		logic             taken;
		logic [BLOCK_W-1:0] got;
		a.blk = '0;
		a.st = ST_OK;
		if (m == MODE_ALLOC) begin
			taken = 1'b0;
			pref = NUM_GROUPS;
			if (free_total != 0) begin
				if (ino != 0 && inodes_per_grp != 0)
					pref = (int'(ino) - 1) / inodes_per_grp;
				if (pref < NUM_GROUPS)
					taken = take_lowest(pref, got);
				for (g = 0; g < NUM_GROUPS && !taken; g++) begin
					if (g != pref)
						taken = take_lowest(g, got);
				end
			end
			if (taken)
				a.blk = got;
			else
				a.st = ST_NO_SPACE;
		end else if (bn != '0) begin
			bnum = bn;
			if (bnum < first_block || bnum - first_block >= TOTAL_BLOCKS) begin
				a.st = ST_OUT_OF_RANGE;
			end else begin
				rel = bnum - first_block;
				if (!used_map[rel]) begin
					a.st = ST_ALREADY_FREE;
				end else begin
					used_map[rel] = 1'b0;
					g = rel / GROUP_BLOCKS;
					if (grp_free[g] < GROUP_BLOCKS)
						grp_free[g]++;
					if (free_total < TOTAL_BLOCKS)
						free_total++;
				end
			end
		end
		return a;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
		mismatches++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Offer one request and record its answer once the beat is taken
	task automatic offer_request(input logic m, input logic [INODE_W-1:0] ino,
			input logic [BLOCK_W-1:0] bn, input logic fixed = 1'b0, input answer_t want = '0);
		answer_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		inode_number <= ino;
		block_number <= bn;
		do @(posedge clk); while (!in_ready);
		got = run_allocator(m, ino, bn);
		answers_due.push_back(fixed ? want : got);
	endtask

	// Input side quiet until every answer is back
	task automatic settle();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_regs(input logic fdb, input logic [IPG_W-1:0] ipg);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FDB;
		cfg_data <= CFG_W'(fdb);
		@(posedge clk);
		cfg_index <= CFG_IPG;
		cfg_data <= ipg;
		@(posedge clk);
		cfg_we <= 1'b0;
		first_block = fdb;
		inodes_per_grp = ipg;
	endtask

	// Mostly allocations and frees of held blocks; the rest odd frees
	task automatic random_traffic(input int count);
		int unsigned        pick, slot;
		logic [INODE_W-1:0] ino;
		logic [BLOCK_W-1:0] bn;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 50 || (pick < 85 && held.size() == 0)) begin
				case ($urandom_range(9))
					0, 1: ino = '0;
					2, 3, 4, 5, 6: ino = INODE_W'(1 + $urandom_range(inodes_per_grp * NUM_GROUPS - 1));
					default: ino = INODE_W'($urandom);
				endcase
				offer_request(MODE_ALLOC, ino, BLOCK_W'($urandom));
			end else if (pick < 85) begin
				slot = $urandom_range(held.size() - 1);
				bn = BLOCK_W'(held[slot] + first_block);
				held.delete(slot);
				offer_request(MODE_FREE, INODE_W'($urandom), bn);
			end else begin
				case ($urandom_range(3))
					0: bn = BLOCK_W'($urandom);
					1: bn = '0;
					// last valid block or the first one past the end
					2: bn = BLOCK_W'(TOTAL_BLOCKS + first_block - $urandom_range(1));
					default: bn = BLOCK_W'($urandom_range(TOTAL_BLOCKS - 1) + first_block);
				endcase
				offer_request(MODE_FREE, INODE_W'($urandom), bn);
			end
		end
	endtask

	// Result side: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result beat with the oldest answer due
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing due: expected none, actual block %0d status %0d",
					$time, allocated_block, status);
			end else begin
				head = answers_due.pop_front();
				if (allocated_block !== head.blk)
					flag_mismatch("allocated_block", head.blk, allocated_block);
				if (status !== head.st)
					flag_mismatch("status", head.st, status);
			end
		end
	end

	// Watchdog on cycles with no beat at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		foreach (used_map[i])
			used_map[i] = 1'b0;
		foreach (grp_free[i])
			grp_free[i] = GROUP_BLOCKS;
		free_total = TOTAL_BLOCKS;
		first_block = 1;
		inodes_per_grp = 1024;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan at the reset settings
		write_regs(1'b1, 16'd1024);
		foreach (plan[i])
			offer_request(plan[i].m, plan[i].ino, plan[i].bn, plan[i].fixed, plan[i].want);
		settle();

		// Low extremes, no idling
		write_regs(1'b0, 16'd1);
		random_traffic(110);
		settle();

		// High extremes, sender mostly idle
		write_regs(1'b1, 16'hFFFF);
		send_idle_pct = 78;
		random_traffic(110);
		settle();

		// Receiver mostly stalled
		write_regs(1'b0, IPG_W'($urandom_range(4096, 2)));
		send_idle_pct = 0;
		recv_stall_pct = 78;
		random_traffic(110);
		settle();

		// Both sides idle now and then
		write_regs(1'b1, IPG_W'($urandom_range(65535, 1)));
		send_idle_pct = 22;
		recv_stall_pct = 22;
		random_traffic(110);
		settle();

		// Backpressure: results held off while requests keep coming,
		// then a full drain before the sender resumes
		write_regs(1'b0, 16'd512);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_asked++;
		random_traffic(20);
		settle();
		random_traffic(20);
		settle();

		// Allocations with wild inodes, then mixed traffic
		write_regs(1'b1, 16'd1024);
		repeat (3)
			offer_request(MODE_ALLOC, INODE_W'($urandom), BLOCK_W'($urandom));
		send_idle_pct = 22;
		recv_stall_pct = 22;
		random_traffic(50);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
